// ===== rtl/core/rk4_pkg.sv =====
`timescale 1ns / 1ps

package rk4_pkg;

  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = $clog2(NUM_REGS);
  localparam int CFG_IDX_W = 4;
  localparam int COEF_W    = 40;
  localparam int VAL_W     = 48;
  localparam int TRIG_W    = 34;
  localparam int SPLIT     = 24;
  localparam int PART_W    = VAL_W - SPLIT + 1;
  localparam int PROD_W    = 64;
  localparam int EXACT_W   = PROD_W + SPLIT;
  localparam int FRAC_W    = 32;
  localparam int TERM_W    = EXACT_W - FRAC_W;
  localparam int SUM_W     = 58;
  localparam int WSUM_W    = 51;
  localparam int DIV_W     = 56;
  localparam int DIGIT_W   = 8;
  localparam int DIV_STEPS = DIV_W / DIGIT_W;
  localparam int QUOT_W    = 49;
  localparam int CNT_W     = 4;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  localparam logic [1:0]       LAST_STAGE = 2'd3;
  localparam logic [1:0]       MID_STAGE  = 2'd2;
  localparam logic [CNT_W-1:0] DRAIN_LAST = CNT_W'(1);
  localparam logic [CNT_W-1:0] DIV_LAST   = CNT_W'(DIV_STEPS);

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [VAL_W-1:0]  val_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_COEF_11,
    REG_COEF_12,
    REG_COEF_21,
    REG_COEF_22,
    REG_COS_FIRST,
    REG_SIN_FIRST,
    REG_COS_SECOND,
    REG_SIN_SECOND
  } reg_idx_e;

  localparam coef_t COEF_RESET [NUM_REGS] = '{
    40'sd386547057, 40'sd1030792151, -40'sd1030792151, -40'sd2190433321,
    40'sd214748365, -40'sd14316558, 40'sd386547057, 40'sd14316558
  };

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_MUL,
    SEQ_DRAIN,
    SEQ_ARG,
    SEQ_DIV,
    SEQ_UPD,
    SEQ_DONE
  } seq_state_e;

  typedef struct packed {
    logic       mul_en;
    logic       comp;
    logic [1:0] term;
    logic       hi;
    logic [1:0] stage;
    logic       arg_en;
    logic       div_start;
    logic       div_step;
    logic       upd_en;
    logic       out_load;
  } ctrl_t;

  typedef struct packed {
    logic       vld;
    logic       comp;
    logic       sat;
    logic [VAL_W-1:0] val;
  } kres_t;

  localparam sum_t SAT_MAX = {{(SUM_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
  localparam sum_t SAT_MIN = {{(SUM_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};

  function automatic logic ovf48(input sum_t x);
    return (x > SAT_MAX) || (x < SAT_MIN);
  endfunction

  function automatic val_t sat48(input sum_t x);
    val_t r;
    if (x > SAT_MAX) begin
      r = SAT_MAX[VAL_W-1:0];
    end else if (x < SAT_MIN) begin
      r = SAT_MIN[VAL_W-1:0];
    end else begin
      r = x[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/rk4_two_state_linear_ode_step.sv =====
`timescale 1ns / 1ps
// Load item: IDLE, then DONE, where the result is registered once the output is free.
// A new item is taken only in IDLE, so each item is finished before the next is accepted.
// Step item: one 40x25 multiplier forms the low and high halves of eight products per stage
// over four stages, then two byte-wise divisions by six follow. A stalled result holds the block.
// Reset clears the state to zero, loads the default coefficients and empties the output.

module rk4_two_state_linear_ode_step import rk4_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 operation_i,
  input  logic [VAL_W-1:0]     load_first_i,
  input  logic [VAL_W-1:0]     load_second_i,
  input  logic [TRIG_W-1:0]    cos_start_i,
  input  logic [TRIG_W-1:0]    sin_start_i,
  input  logic [TRIG_W-1:0]    cos_mid_i,
  input  logic [TRIG_W-1:0]    sin_mid_i,
  input  logic [TRIG_W-1:0]    cos_end_i,
  input  logic [TRIG_W-1:0]    sin_end_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [VAL_W-1:0]     first_value_o,
  output logic [VAL_W-1:0]     second_value_o,
  output logic                 overflow_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [COEF_W-1:0]    cfg_data_i
);

  ctrl_t ctrl;
  kres_t kres;
  logic  in_xfer, out_free;

  coef_t coef_q [NUM_REGS];
  val_t  u1_q, u2_q, v1_q, v2_q, k1_q, k2_q;
  logic signed [WSUM_W-1:0] wsum1_q, wsum2_q, wsum1_d, wsum2_d;
  logic signed [TRIG_W-1:0] cos_start_q, sin_start_q, cos_mid_q, sin_mid_q;
  logic signed [TRIG_W-1:0] cos_end_q, sin_end_q;
  logic ovf_q, out_valid_q;
  logic [VAL_W-1:0] first_q, second_q;
  logic             out_ovf_q;

  coef_t a_sel;
  val_t  b_sel;
  logic signed [TRIG_W-1:0] cos_sel, sin_sel;

  val_t  add1, add2, arg1, arg2;
  sum_t  asum1, asum2;
  logic  arg_ovf;
  logic signed [WSUM_W-1:0] kw1, kw2;

  logic signed [WSUM_W-1:0] wsum_sel, wmag;
  logic [DIV_W-1:0]  dividend;
  logic [QUOT_W-1:0] quot;
  val_t  u_sel;
  sum_t  usum;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  rk4_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (operation_i),
    .out_free_i (out_free),
    .in_stall_o (in_stall_o),
    .ctrl_o     (ctrl)
  );

  // operand selection for the shared multiplier
  always_comb begin
    case (ctrl.stage)
      2'd0: begin
        cos_sel = cos_start_q;
        sin_sel = sin_start_q;
      end
      LAST_STAGE: begin
        cos_sel = cos_end_q;
        sin_sel = sin_end_q;
      end
      default: begin
        cos_sel = cos_mid_q;
        sin_sel = sin_mid_q;
      end
    endcase
    case ({ctrl.comp, ctrl.term})
      3'b000:  a_sel = coef_q[REG_COEF_11];
      3'b001:  a_sel = coef_q[REG_COEF_12];
      3'b010:  a_sel = coef_q[REG_COS_FIRST];
      3'b011:  a_sel = coef_q[REG_SIN_FIRST];
      3'b100:  a_sel = coef_q[REG_COEF_21];
      3'b101:  a_sel = coef_q[REG_COEF_22];
      3'b110:  a_sel = coef_q[REG_COS_SECOND];
      default: a_sel = coef_q[REG_SIN_SECOND];
    endcase
    case (ctrl.term)
      2'd0:    b_sel = v1_q;
      2'd1:    b_sel = v2_q;
      2'd2:    b_sel = {{(VAL_W-TRIG_W){cos_sel[TRIG_W-1]}}, cos_sel};
      default: b_sel = {{(VAL_W-TRIG_W){sin_sel[TRIG_W-1]}}, sin_sel};
    endcase
  end

  rk4_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .a_i    (a_sel),
    .b_i    (b_sel),
    .kres_o (kres)
  );

  // stage arguments and weighted sum
  always_comb begin
    if (ctrl.stage == MID_STAGE) begin
      add1 = k1_q;
      add2 = k2_q;
    end else begin
      add1 = {k1_q[VAL_W-1], k1_q[VAL_W-1:1]};
      add2 = {k2_q[VAL_W-1], k2_q[VAL_W-1:1]};
    end
    asum1   = $signed({{(SUM_W-VAL_W){u1_q[VAL_W-1]}}, u1_q})
            + $signed({{(SUM_W-VAL_W){add1[VAL_W-1]}}, add1});
    asum2   = $signed({{(SUM_W-VAL_W){u2_q[VAL_W-1]}}, u2_q})
            + $signed({{(SUM_W-VAL_W){add2[VAL_W-1]}}, add2});
    arg1    = sat48(asum1);
    arg2    = sat48(asum2);
    arg_ovf = (ctrl.stage != LAST_STAGE) && (ovf48(asum1) || ovf48(asum2));
    kw1     = $signed({{(WSUM_W-VAL_W){k1_q[VAL_W-1]}}, k1_q});
    kw2     = $signed({{(WSUM_W-VAL_W){k2_q[VAL_W-1]}}, k2_q});
    if (ctrl.stage == 2'd1 || ctrl.stage == MID_STAGE) begin
      kw1 = kw1 <<< 1;
      kw2 = kw2 <<< 1;
    end
    wsum1_d = (ctrl.stage == 2'd0 ? '0 : wsum1_q) + kw1;
    wsum2_d = (ctrl.stage == 2'd0 ? '0 : wsum2_q) + kw2;
  end

  // division by six on the magnitude, sign restored in the update
  assign wsum_sel = ctrl.comp ? wsum2_q : wsum1_q;
  assign wmag     = wsum_sel[WSUM_W-1] ? -wsum_sel : wsum_sel;
  assign dividend = {{(DIV_W-WSUM_W){1'b0}}, wmag};

  rk4_div6 u_div6 (
    .clk_i      (clk_i),
    .start_i    (ctrl.div_start),
    .step_i     (ctrl.div_step),
    .dividend_i (dividend),
    .quot_o     (quot)
  );

  assign u_sel = ctrl.comp ? u2_q : u1_q;
  assign usum  = wsum_sel[WSUM_W-1]
               ? $signed({{(SUM_W-VAL_W){u_sel[VAL_W-1]}}, u_sel})
                 - $signed({{(SUM_W-QUOT_W){1'b0}}, quot})
               : $signed({{(SUM_W-VAL_W){u_sel[VAL_W-1]}}, u_sel})
                 + $signed({{(SUM_W-QUOT_W){1'b0}}, quot});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        coef_q[i] <= COEF_RESET[i];
      end
      u1_q        <= '0;
      u2_q        <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_index_i < CFG_IDX_W'(NUM_REGS))) begin
        coef_q[cfg_index_i[REG_IDX_W-1:0]] <= cfg_data_i;
      end
      if (in_xfer) begin
        ovf_q <= 1'b0;
        if (operation_i == OP_LOAD) begin
          u1_q <= load_first_i;
          u2_q <= load_second_i;
        end
      end else begin
        if ((kres.vld && kres.sat) || (ctrl.arg_en && arg_ovf)
            || (ctrl.upd_en && ovf48(usum))) begin
          ovf_q <= 1'b1;
        end
        if (ctrl.upd_en) begin
          if (ctrl.comp) begin
            u2_q <= sat48(usum);
          end else begin
            u1_q <= sat48(usum);
          end
        end
      end
      if (ctrl.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      v1_q        <= u1_q;
      v2_q        <= u2_q;
      cos_start_q <= cos_start_i;
      sin_start_q <= sin_start_i;
      cos_mid_q   <= cos_mid_i;
      sin_mid_q   <= sin_mid_i;
      cos_end_q   <= cos_end_i;
      sin_end_q   <= sin_end_i;
    end
    if (kres.vld) begin
      if (kres.comp) begin
        k2_q <= kres.val;
      end else begin
        k1_q <= kres.val;
      end
    end
    if (ctrl.arg_en) begin
      v1_q    <= arg1;
      v2_q    <= arg2;
      wsum1_q <= wsum1_d;
      wsum2_q <= wsum2_d;
    end
    if (ctrl.out_load) begin
      first_q   <= u1_q;
      second_q  <= u2_q;
      out_ovf_q <= ovf_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign first_value_o  = first_q;
  assign second_value_o = second_q;
  assign overflow_o     = out_ovf_q;

endmodule

// ===== rtl/core/rk4_seq.sv =====
`timescale 1ns / 1ps

module rk4_seq import rk4_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  op_i,
  input  logic  out_free_i,
  output logic  in_stall_o,
  output ctrl_t ctrl_o
);

  seq_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [1:0]       stage_q, stage_d;
  logic             comp_q, comp_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
      cnt_q   <= '0;
      stage_q <= '0;
      comp_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      stage_q <= stage_d;
      comp_q  <= comp_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    stage_d      = stage_q;
    comp_d       = comp_q;
    ctrl_o       = '0;
    ctrl_o.comp  = comp_q;
    ctrl_o.term  = cnt_q[2:1];
    ctrl_o.hi    = cnt_q[0];
    ctrl_o.stage = stage_q;
    case (state_q)
      SEQ_IDLE: begin
        if (in_valid_i) begin
          cnt_d   = '0;
          stage_d = '0;
          comp_d  = 1'b0;
          state_d = (op_i == OP_STEP) ? SEQ_MUL : SEQ_DONE;
        end
      end
      SEQ_MUL: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.comp   = cnt_q[3];
        cnt_d         = cnt_q + CNT_W'(1);
        if (&cnt_q) begin
          cnt_d   = '0;
          state_d = SEQ_DRAIN;
        end
      end
      SEQ_DRAIN: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == DRAIN_LAST) begin
          state_d = SEQ_ARG;
        end
      end
      SEQ_ARG: begin
        ctrl_o.arg_en = 1'b1;
        cnt_d         = '0;
        if (stage_q == LAST_STAGE) begin
          comp_d  = 1'b0;
          state_d = SEQ_DIV;
        end else begin
          stage_d = stage_q + 2'd1;
          state_d = SEQ_MUL;
        end
      end
      SEQ_DIV: begin
        ctrl_o.div_start = (cnt_q == '0);
        ctrl_o.div_step  = (cnt_q != '0);
        cnt_d            = cnt_q + CNT_W'(1);
        if (cnt_q == DIV_LAST) begin
          state_d = SEQ_UPD;
        end
      end
      SEQ_UPD: begin
        ctrl_o.upd_en = 1'b1;
        cnt_d         = '0;
        if (!comp_q) begin
          comp_d  = 1'b1;
          state_d = SEQ_DIV;
        end else begin
          state_d = SEQ_DONE;
        end
      end
      SEQ_DONE: begin
        if (out_free_i) begin
          ctrl_o.out_load = 1'b1;
          state_d         = SEQ_IDLE;
        end
      end
      default: begin
        state_d = SEQ_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != SEQ_IDLE);

endmodule

// ===== rtl/core/rk4_mac.sv =====
`timescale 1ns / 1ps

module rk4_mac import rk4_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  ctrl_t ctrl_i,
  input  coef_t a_i,
  input  val_t  b_i,
  output kres_t kres_o
);

  typedef struct packed {
    logic vld;
    logic comp;
    logic hi;
    logic first;
    logic last;
  } tag_t;

  tag_t tag1_q, tag1_d, tag2_q, tag2_d;

  logic signed [PART_W-1:0]        b_part;
  logic signed [COEF_W+PART_W-1:0] prod_w;
  logic signed [PROD_W-1:0]        mul_q, lo_q;
  logic signed [EXACT_W-1:0]       exact;
  logic signed [TERM_W-1:0]        term_q;
  sum_t                            acc_q, acc_d;

  assign b_part = ctrl_i.hi ? {b_i[VAL_W-1], b_i[VAL_W-1:SPLIT]}
                            : {1'b0, b_i[SPLIT-1:0]};
  assign prod_w = a_i * b_part;

  always_comb begin
    tag1_d.vld   = ctrl_i.mul_en;
    tag1_d.comp  = ctrl_i.comp;
    tag1_d.hi    = ctrl_i.hi;
    tag1_d.first = (ctrl_i.term == 2'd0);
    tag1_d.last  = (&ctrl_i.term);
    tag2_d       = tag1_q;
    tag2_d.vld   = tag1_q.vld && tag1_q.hi;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
    end else begin
      tag1_q <= tag1_d;
      tag2_q <= tag2_d;
    end
  end

  // exact product of coefficient and full operand, floored by 2^32
  assign exact = $signed({mul_q, {SPLIT{1'b0}}})
               + $signed({{SPLIT{lo_q[PROD_W-1]}}, lo_q});

  assign acc_d = (tag2_q.first ? '0 : acc_q)
               + $signed({{(SUM_W-TERM_W){term_q[TERM_W-1]}}, term_q});

  always_ff @(posedge clk_i) begin
    mul_q <= prod_w[PROD_W-1:0];
    if (tag1_q.vld && !tag1_q.hi) begin
      lo_q <= mul_q;
    end
    if (tag1_q.vld && tag1_q.hi) begin
      term_q <= exact[EXACT_W-1:FRAC_W];
    end
    if (tag2_q.vld) begin
      acc_q <= acc_d;
    end
  end

  always_comb begin
    kres_o.vld  = tag2_q.vld && tag2_q.last;
    kres_o.comp = tag2_q.comp;
    kres_o.sat  = ovf48(acc_d);
    kres_o.val  = sat48(acc_d);
  end

endmodule

// ===== rtl/core/rk4_div6.sv =====
`timescale 1ns / 1ps

module rk4_div6 import rk4_pkg::*; (
  input  logic              clk_i,
  input  logic              start_i,
  input  logic              step_i,
  input  logic [DIV_W-1:0]  dividend_i,
  output logic [QUOT_W-1:0] quot_o
);

  logic [DIV_W-1:0]   dq_q, dq_d;
  logic [2:0]         rem_q, rem_d;
  logic [DIGIT_W-1:0] qbits;
  logic [3:0]         r4;

  // restoring division by six, one byte of dividend per cycle while step_i is high
  always_comb begin
    rem_d = rem_q;
    qbits = '0;
    r4    = '0;
    for (int i = 0; i < DIGIT_W; i++) begin
      r4 = {rem_d, dq_q[DIV_W-1-i]};
      if (r4 >= 4'd6) begin
        qbits[DIGIT_W-1-i] = 1'b1;
        r4                 = r4 - 4'd6;
      end
      rem_d = r4[2:0];
    end
    dq_d = {dq_q[DIV_W-DIGIT_W-1:0], qbits};
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
    end else if (step_i) begin
      dq_q  <= dq_d;
      rem_q <= rem_d;
    end
  end

  assign quot_o = dq_q[QUOT_W-1:0];

endmodule

// ===== tb/tb_rk4_two_state_linear_ode_step.sv =====
`timescale 1ns / 1ps

module tb_rk4_two_state_linear_ode_step import rk4_pkg::*; ();

  localparam int          CLK_PERIOD     = 8;
  localparam int          WATCHDOG_LIMIT = 3000;
  localparam int          LONG_HOLD      = 500;
  localparam longint      VAL_MAX        = (64'sd1 <<< (VAL_W - 1)) - 1;
  localparam longint      VAL_MIN        = -VAL_MAX - 1;

  typedef logic signed [TRIG_W-1:0] trig_t;

  localparam trig_t TRIG_ONE    = trig_t'(64'sd1 <<< FRAC_W);
  localparam trig_t TRIG_TOP    = {1'b0, {(TRIG_W-1){1'b1}}};
  localparam trig_t TRIG_BOTTOM = {1'b1, {(TRIG_W-1){1'b0}}};
  localparam coef_t COEF_TOP    = {1'b0, {(COEF_W-1){1'b1}}};
  localparam coef_t COEF_BOTTOM = {1'b1, {(COEF_W-1){1'b0}}};

  typedef enum {
    GAINS_DEFAULT,
    GAINS_SMALL,
    GAINS_WIDE,
    GAINS_TOP,
    GAINS_BOTTOM,
    GAINS_MIXED
  } gain_set_e;

  typedef struct packed {
    logic  op;
    val_t  load_a;
    val_t  load_b;
    trig_t cos_s;
    trig_t sin_s;
    trig_t cos_m;
    trig_t sin_m;
    trig_t cos_e;
    trig_t sin_e;
  } ode_item_t;

  typedef struct packed {
    val_t first;
    val_t second;
    logic clamped;
  } ode_state_t;

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_stall_o;
  logic                 operation_i    = 1'b0;
  logic [VAL_W-1:0]     load_first_i   = '0;
  logic [VAL_W-1:0]     load_second_i  = '0;
  logic [TRIG_W-1:0]    cos_start_i    = '0;
  logic [TRIG_W-1:0]    sin_start_i    = '0;
  logic [TRIG_W-1:0]    cos_mid_i      = '0;
  logic [TRIG_W-1:0]    sin_mid_i      = '0;
  logic [TRIG_W-1:0]    cos_end_i      = '0;
  logic [TRIG_W-1:0]    sin_end_i      = '0;
  logic                 out_valid_o;
  logic                 out_stall_i    = 1'b0;
  logic [VAL_W-1:0]     first_value_o;
  logic [VAL_W-1:0]     second_value_o;
  logic                 overflow_o;
  logic                 cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i    = '0;
  logic [COEF_W-1:0]    cfg_data_i     = '0;

  ode_item_t  pending_items[$];
  ode_state_t expected_states[$];

  coef_t      model_gain [NUM_REGS];
  val_t       model_u1;
  val_t       model_u2;
  bit         step_clamped;

  bit         tx_idle_en;
  bit         rx_idle_en;
  bit         item_offered;
  ode_item_t  offered;
  int         send_gap;
  int         rx_wait;
  int         hold_left;
  bit         held_off;
  bit         stall_next;
  int         results_seen;
  int         mismatches;
  int         quiet_cycles;
  ode_state_t got;
  ode_state_t want;

  rk4_two_state_linear_ode_step dut (.*);

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---- predictor ----

  function automatic longint scaled_mul(input longint g, input longint v);
    logic signed [127:0] gw;
    logic signed [127:0] vw;
    logic signed [127:0] p;
    gw = g;
    vw = v;
    p  = gw * vw;
    return longint'(p >>> FRAC_W);
  endfunction

  function automatic longint clamp48(input longint x);
    longint r;
    r = x;
    if (x > VAL_MAX) begin
      r = VAL_MAX;
      step_clamped = 1'b1;
    end else if (x < VAL_MIN) begin
      r = VAL_MIN;
      step_clamped = 1'b1;
    end
    return r;
  endfunction

  function automatic void stage_rates(input longint v1, input longint v2, input longint c,
                                      input longint s, output longint k1, output longint k2);
    k1 = clamp48(scaled_mul(model_gain[REG_COEF_11], v1) +
                 scaled_mul(model_gain[REG_COEF_12], v2) +
                 scaled_mul(model_gain[REG_COS_FIRST], c) +
                 scaled_mul(model_gain[REG_SIN_FIRST], s));
    k2 = clamp48(scaled_mul(model_gain[REG_COEF_21], v1) +
                 scaled_mul(model_gain[REG_COEF_22], v2) +
                 scaled_mul(model_gain[REG_COS_SECOND], c) +
                 scaled_mul(model_gain[REG_SIN_SECOND], s));
  endfunction

  function automatic ode_state_t advance_ode(input ode_item_t it);
    longint     u1, u2, a1, a2, b1, b2, c1, c2, d1, d2;
    ode_state_t r;
    step_clamped = 1'b0;
    if (it.op == OP_LOAD) begin
      model_u1 = it.load_a;
      model_u2 = it.load_b;
    end else begin
      u1 = model_u1;
      u2 = model_u2;
      stage_rates(u1, u2, it.cos_s, it.sin_s, a1, a2);
      stage_rates(clamp48(u1 + (a1 >>> 1)), clamp48(u2 + (a2 >>> 1)),
                  it.cos_m, it.sin_m, b1, b2);
      stage_rates(clamp48(u1 + (b1 >>> 1)), clamp48(u2 + (b2 >>> 1)),
                  it.cos_m, it.sin_m, c1, c2);
      stage_rates(clamp48(u1 + c1), clamp48(u2 + c2), it.cos_e, it.sin_e, d1, d2);
      // weighted sum / 6 truncates toward zero
      model_u1 = val_t'(clamp48(u1 + (a1 + 2 * b1 + 2 * c1 + d1) / 6));
      model_u2 = val_t'(clamp48(u2 + (a2 + 2 * b2 + 2 * c2 + d2) / 6));
    end
    r.first   = model_u1;
    r.second  = model_u2;
    r.clamped = step_clamped;
    return r;
  endfunction

  // ---- stimulus generation ----

  function automatic void queue_item(input ode_item_t it);
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic val_t rand_val();
    val_t r;
    case ($urandom_range(0, 7))
      0:       r = val_t'(VAL_MAX);
      1:       r = val_t'(VAL_MIN);
      2:       r = val_t'({$urandom, $urandom});
      3:       r = '0;
      default: r = val_t'($signed(37'({$urandom, $urandom})));
    endcase
    return r;
  endfunction

  function automatic trig_t rand_trig();
    logic [63:0] raw;
    trig_t       r;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       r = TRIG_ONE;
      1:       r = -TRIG_ONE;
      2:       r = TRIG_TOP;
      3:       r = TRIG_BOTTOM;
      4:       r = trig_t'(raw);
      default: r = trig_t'(longint'(raw % 64'd8589934593) - (64'sd1 <<< FRAC_W));
    endcase
    return r;
  endfunction

  function automatic trig_t to_q32(input real x);
    longint q;
    q = x * 4294967296.0;
    return trig_t'(q);
  endfunction

  function automatic ode_item_t make_item(input logic op, input val_t a, input val_t b,
                                          input trig_t tv);
    ode_item_t it;
    it.op     = op;
    it.load_a = a;
    it.load_b = b;
    it.cos_s  = tv;
    it.sin_s  = tv;
    it.cos_m  = tv;
    it.sin_m  = tv;
    it.cos_e  = tv;
    it.sin_e  = tv;
    return it;
  endfunction

  function automatic ode_item_t random_step();
    ode_item_t it;
    it       = make_item(OP_STEP, rand_val(), rand_val(), '0);
    it.cos_s = rand_trig();
    it.sin_s = rand_trig();
    it.cos_m = rand_trig();
    it.sin_m = rand_trig();
    it.cos_e = rand_trig();
    it.sin_e = rand_trig();
    return it;
  endfunction

  task automatic queue_directed();
    // trig fields ignored on load, load fields ignored on step
    queue_item(make_item(OP_LOAD, '0, '0, TRIG_TOP));
    queue_item(make_item(OP_STEP, '0, '0, '0));
    queue_item(make_item(OP_STEP, val_t'(VAL_MAX), val_t'(VAL_MIN), TRIG_ONE));
    queue_item(make_item(OP_STEP, '0, '0, -TRIG_ONE));
    queue_item(make_item(OP_LOAD, val_t'(VAL_MAX), val_t'(VAL_MIN), '0));
    queue_item(make_item(OP_STEP, '0, '0, TRIG_ONE));
    queue_item(make_item(OP_LOAD, val_t'(VAL_MIN), val_t'(VAL_MAX), TRIG_BOTTOM));
    queue_item(make_item(OP_STEP, '0, '0, -TRIG_ONE));
    queue_item(make_item(OP_LOAD, val_t'(VAL_MIN), val_t'(VAL_MIN), '0));
    // trig beyond unity, used as given
    queue_item(make_item(OP_STEP, '0, '0, TRIG_BOTTOM));
    queue_item(make_item(OP_LOAD, val_t'(VAL_MAX), val_t'(VAL_MAX), '0));
    queue_item(make_item(OP_STEP, '1, '1, TRIG_TOP));
    queue_item(make_item(OP_LOAD, '1, val_t'(1), '0));
    queue_item(make_item(OP_STEP, '0, '0, '0));
    queue_item(make_item(OP_LOAD, val_t'(64'sd1 <<< FRAC_W), '0, '0));
    queue_item(random_step());
    queue_item(random_step());
  endtask

  task automatic queue_sessions(input int count);
    ode_item_t it;
    int        left;
    int        steps;
    real       t;
    real       h;
    left = count;
    while (left > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        it    = random_step();
        it.op = ($urandom_range(0, 1) == 0) ? OP_LOAD : OP_STEP;
        queue_item(it);
        left--;
      end else begin
        queue_item(make_item(OP_LOAD, rand_val(), rand_val(), rand_trig()));
        left--;
        steps = $urandom_range(1, 12);
        t     = $urandom_range(0, 6283) / 1000.0;
        h     = $urandom_range(1, 800) / 1000.0;
        for (int s = 0; s < steps && left > 0; s++) begin
          if ($urandom_range(0, 3) == 0) begin
            it = random_step();
          end else begin
            it       = make_item(OP_STEP, rand_val(), rand_val(), '0);
            it.cos_s = to_q32($cos(t));
            it.sin_s = to_q32($sin(t));
            it.cos_m = to_q32($cos(t + h / 2.0));
            it.sin_m = to_q32($sin(t + h / 2.0));
            it.cos_e = to_q32($cos(t + h));
            it.sin_e = to_q32($sin(t + h));
          end
          queue_item(it);
          left--;
          t = t + h;
        end
      end
    end
  endtask

  // ---- configuration ----

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input coef_t value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    if (idx < NUM_REGS) begin
      model_gain[idx[REG_IDX_W-1:0]] = value;
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic program_gains(input gain_set_e set);
    coef_t g;
    for (int i = 0; i < NUM_REGS; i++) begin
      case (set)
        GAINS_DEFAULT: g = COEF_RESET[i];
        GAINS_SMALL:   g = coef_t'($signed(34'({$urandom, $urandom})));
        GAINS_WIDE:    g = coef_t'({$urandom, $urandom});
        GAINS_TOP:     g = COEF_TOP;
        GAINS_BOTTOM:  g = COEF_BOTTOM;
        default:       g = (i % 2 == 0) ? COEF_TOP : ((i < 4) ? COEF_BOTTOM : '0);
      endcase
      write_reg(CFG_IDX_W'(i), g);
    end
  endtask

  // indices past the register file must be ignored
  task automatic poke_unused_indices();
    for (int i = NUM_REGS; i < 2 ** CFG_IDX_W; i++) begin
      write_reg(CFG_IDX_W'(i), coef_t'({$urandom, $urandom}));
    end
  endtask

  task automatic wait_for_drain();
    while (pending_items.size() > 0 || item_offered || expected_states.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  // ---- sender ----

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      item_offered = 1'b0;
      send_gap     = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_states.insert(expected_states.size(), advance_ode(offered));
        item_offered = 1'b0;
        send_gap     = tx_idle_en ? $urandom_range(0, 15) : 0;
      end
      if (!item_offered) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_items.size() > 0) begin
          offered       = pending_items.pop_front();
          item_offered  = 1'b1;
          operation_i   <= offered.op;
          load_first_i  <= offered.load_a;
          load_second_i <= offered.load_b;
          cos_start_i   <= offered.cos_s;
          sin_start_i   <= offered.sin_s;
          cos_mid_i     <= offered.cos_m;
          sin_mid_i     <= offered.sin_m;
          cos_end_i     <= offered.cos_e;
          sin_end_i     <= offered.sin_e;
        end
      end
      in_valid_i <= item_offered;
    end
  end

  // ---- receiver and checker ----

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_wait     = 0;
      hold_left   = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got.first   = first_value_o;
        got.second  = second_value_o;
        got.clamped = overflow_o;
        if (expected_states.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected result: first %h second %h overflow %b",
                     got.first, got.second, got.clamped);
          end
          mismatches++;
        end else begin
          want = expected_states.pop_front();
          if (got.first !== want.first || got.second !== want.second ||
              got.clamped !== want.clamped) begin
            if (mismatches < 10) begin
              $display("result %0d: expected first %h second %h overflow %b, got %h %h %b",
                       results_seen, want.first, want.second, want.clamped,
                       got.first, got.second, got.clamped);
            end
            mismatches++;
          end
        end
        results_seen++;
        rx_wait = rx_idle_en ? $urandom_range(0, 15) : 0;
        // one long hold-off so the block backs up into its input
        if (!held_off && results_seen >= 300 && pending_items.size() > 8) begin
          hold_left = LONG_HOLD;
          held_off  = 1'b1;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (rx_wait > 0) begin
        if (out_valid_o) begin
          rx_wait--;
        end
        stall_next = 1'b1;
      end else begin
        stall_next = 1'b0;
      end
      out_stall_i <= stall_next;
    end
  end

  // ---- watchdog: cycles without any transfer while work is outstanding ----

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (pending_items.size() == 0 && !item_offered && expected_states.size() == 0)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("rk4_two_state_linear_ode_step regression: fail");
        $finish;
      end
    end
  end

  // ---- phases ----

  initial begin
    model_gain   = COEF_RESET;
    model_u1     = '0;
    model_u2     = '0;
    held_off     = 1'b0;
    results_seen = 0;
    mismatches   = 0;
    quiet_cycles = 0;
    tx_idle_en   = 1'b1;
    rx_idle_en   = 1'b1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_directed();
    queue_sessions(120);
    wait_for_drain();

    program_gains(GAINS_SMALL);
    poke_unused_indices();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    queue_sessions(150);
    wait_for_drain();

    program_gains(GAINS_TOP);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    queue_sessions(60);
    wait_for_drain();

    program_gains(GAINS_BOTTOM);
    tx_idle_en = 1'b0;
    queue_sessions(60);
    wait_for_drain();

    program_gains(GAINS_MIXED);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b0;
    queue_sessions(60);
    wait_for_drain();

    program_gains(GAINS_WIDE);
    rx_idle_en = 1'b1;
    queue_sessions(150);
    wait_for_drain();

    program_gains(GAINS_SMALL);
    tx_idle_en = 1'b0;
    queue_sessions(150);
    wait_for_drain();

    program_gains(GAINS_DEFAULT);
    tx_idle_en = 1'b1;
    queue_sessions(120);
    wait_for_drain();

    // allow a stray late result to show up
    repeat (120) @(posedge clk_i);
    if (mismatches == 0 && expected_states.size() == 0) begin
      $display("rk4_two_state_linear_ode_step regression: pass");
    end else begin
      $display("rk4_two_state_linear_ode_step regression: fail");
    end
    $finish;
  end

endmodule
